[design/msfas_pkg.sv]
// Shared types, constants and register codes for the frame alignment scheduler.
package msfas_pkg;

  // Default sizes
  localparam int SLOTS_DEF           = 8;
  localparam int BACKLOG_DEPTH_DEF   = 16;
  localparam int FRAMES_PER_CALL_DEF = 8;

  // Field widths
  localparam int PTS_W     = 63;
  localparam int OPTS_W    = 62;
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int ALU_W     = 66;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_AUTO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 3'd7;

  // Register reset values
  localparam logic [61:0]        WINDOW_RST   = 62'd40000000;
  localparam logic [61:0]        QUEUE_RST    = 62'd500000000;
  localparam logic signed [62:0] FREEZE_RST   = 63'sd10000000000;
  localparam logic [1:0]         MISSING_RST  = 2'd0;
  localparam logic               REF_AUTO_RST = 1'b0;
  localparam logic [29:0]        INTERVAL_RST = 30'd33333333;
  localparam logic [7:0]         VISIBLE_RST  = 8'd1;
  localparam logic [4:0]         BUDGET_RST   = 5'd15;

  // Compensation modes for an empty window
  localparam logic [1:0] MODE_FREEZE      = 2'd0;
  localparam logic [1:0] MODE_BLACK       = 2'd1;
  localparam logic [1:0] MODE_PLACEHOLDER = 2'd2;
  localparam logic [1:0] MODE_SKIP        = 2'd3;

  // Per-slot actions
  localparam logic [2:0] ACT_NEW         = 3'd0;
  localparam logic [2:0] ACT_FREEZE      = 3'd1;
  localparam logic [2:0] ACT_BLACK       = 3'd2;
  localparam logic [2:0] ACT_PLACEHOLDER = 3'd3;
  localparam logic [2:0] ACT_SKIP        = 3'd4;
  localparam logic [2:0] ACT_HIDDEN      = 3'd5;

  localparam logic [OPTS_W-1:0] OPTS_MAX = {OPTS_W{1'b1}};

  // Request to the shared add/compare unit
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  // Compare flags of the sum against operand c
  typedef struct packed {
    logic lt;
    logic le;
    logic gt;
  } alu_flags_t;

  // Sign-extend a timestamp to the unit width
  function automatic logic [ALU_W-1:0] sext_pts(input logic [PTS_W-1:0] v);
    return {{(ALU_W-PTS_W){v[PTS_W-1]}}, v};
  endfunction

endpackage

[design/msfas_alu.sv]
// Shared signed add/subtract unit with a compare of the result.
module msfas_alu
  import msfas_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] sum,
  output alu_flags_t       flags
);

  logic signed [ALU_W-1:0] res;

  // Add or subtract, then compare against the threshold
  always_comb begin
    if (req.sub) begin
      res = $signed(req.a) - $signed(req.b);
    end else begin
      res = $signed(req.a) + $signed(req.b);
    end
    flags.lt = res < $signed(req.c);
    flags.le = res <= $signed(req.c);
    flags.gt = res > $signed(req.c);
  end

  assign sum = res;

endmodule

[design/multi_source_frame_alignment_scheduler.sv]
// Top level of the multi-source frame alignment scheduler.
// Each input transaction is a source-frame arrival or a flush; the block queues arrivals in a
// per-slot backlog memory and then composes up to FRAMES_PER_CALL output frames, giving one
// decision per slot in slot order, with tuser[1] set on the final decision of the input. The
// block takes one input at a time: s_tready is high only while it is idle. An input passes
// through the threshold steps PREP_A to PREP_C and the queuing step after acceptance, and a
// finish step at the end. Each composed frame reads the main reference and forms the output
// timestamp; automatic reference search instead visits every slot and compares each visible
// slot with a backlog. Each slot then gets its decision, and a visible slot reads its backlog
// entries one at a time. A stale window costs the reference search plus the select on the
// reference, and receiver stalls hold the output. The single read port of the backlog memory
// and the one shared add/compare unit serialise this work. No clearing pass follows reset.
module multi_source_frame_alignment_scheduler
  import msfas_pkg::*;
#(
  parameter int SLOTS           = SLOTS_DEF,
  parameter int BACKLOG_DEPTH   = BACKLOG_DEPTH_DEF,
  parameter int FRAMES_PER_CALL = FRAMES_PER_CALL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,   // slot[2:0], pts[65:3], zero[71:66]
  input  logic [0:0]           s_tuser,   // req_type[0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [135:0]         m_tdata,   // slot_id[2:0], action[5:3], source_pts[68:6],
                                          // frame_pts[130:69], zero[135:131]
  output logic                 m_tlast,   // end_of_frame
  output logic [1:0]           m_tuser    // keyframe[0], last[1]
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(BACKLOG_DEPTH);
  localparam int CNT_W  = $clog2(BACKLOG_DEPTH + 1);
  localparam int MEM_N  = SLOTS * BACKLOG_DEPTH;
  localparam int AW     = $clog2(MEM_N);
  localparam int FC_W   = $clog2(FRAMES_PER_CALL + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [18:0] {
    ST_IDLE       = 19'd1 << 0,
    ST_PREP_A     = 19'd1 << 1,
    ST_PREP_B     = 19'd1 << 2,
    ST_PREP_C     = 19'd1 << 3,
    ST_INGEST     = 19'd1 << 4,
    ST_REF        = 19'd1 << 5,
    ST_REF_MAIN   = 19'd1 << 6,
    ST_ES_CHK     = 19'd1 << 7,
    ST_ES_CMP     = 19'd1 << 8,
    ST_ES_END     = 19'd1 << 9,
    ST_STALE_CHK  = 19'd1 << 10,
    ST_FPTS       = 19'd1 << 11,
    ST_SLOT_START = 19'd1 << 12,
    ST_CH_RD      = 19'd1 << 13,
    ST_CH_EV      = 19'd1 << 14,
    ST_CH_PICK    = 19'd1 << 15,
    ST_DECIDE     = 19'd1 << 16,
    ST_EMIT       = 19'd1 << 17,
    ST_FINISH     = 19'd1 << 18
  } state_t;

  typedef enum logic [1:0] {
    PH_TRIM = 2'd0,
    PH_DROP = 2'd1,
    PH_SCAN = 2'd2
  } phase_t;

  // Configuration registers
  logic [61:0]        window_ns;
  logic [61:0]        age_limit_ns;
  logic signed [62:0] freeze_upgrade_ns;
  logic [1:0]         missing_mode;
  logic               reference_auto;
  logic [29:0]        frame_interval_ns;
  logic [7:0]         visible_mask;
  logic [4:0]         backlog_budget;

  // Per-slot state
  logic [IDX_W-1:0]   head      [SLOTS];
  logic [CNT_W-1:0]   count     [SLOTS];
  logic [PTS_W-1:0]   hold_pts  [SLOTS];
  logic [PTS_W-1:0]   hold_use  [SLOTS];
  logic [SLOTS-1:0]   has_hold;
  logic [SLOTS-1:0]   ever_had;
  logic [SLOTS-1:0]   ended;
  logic [OPTS_W-1:0]  last_out_pts;
  logic               last_out_valid;

  // Sequencer registers
  state_t             state;
  phase_t             phase;
  logic               req_flush;
  logic               in_ok;
  logic [PTS_W-1:0]   in_pts;
  logic [SLOT_W-1:0]  cur;
  logic [SLOT_W-1:0]  ref_slot;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   best;
  logic               found;
  logic               stale_ctx;
  logic [PTS_W-1:0]   target;
  logic [PTS_W-1:0]   picked;
  logic [OPTS_W-1:0]  fpts;
  logic               key;
  logic [FC_W-1:0]    emitted;
  logic [ALU_W-1:0]   wq;
  logic [ALU_W-1:0]   neg_wq;
  logic [ALU_W-1:0]   neg_q;
  logic [2:0]         res_action;
  logic [PTS_W-1:0]   res_src;

  // Pending decision, held until the next one shows whether it is the final one
  logic               pend_valid;
  logic [2:0]         pend_slot;
  logic [2:0]         pend_action;
  logic [PTS_W-1:0]   pend_src;
  logic [OPTS_W-1:0]  pend_fpts;
  logic               pend_key;
  logic               pend_eof;

  // Output register
  logic [2:0]         out_slot;
  logic [2:0]         out_action;
  logic [PTS_W-1:0]   out_src;
  logic [OPTS_W-1:0]  out_fpts;
  logic               out_key;
  logic               out_eof;
  logic               out_last;

  // Backlog memory
  logic [PTS_W-1:0]   mem [MEM_N];
  logic [PTS_W-1:0]   mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;

  logic [SLOT_W-1:0]  sel;
  logic [IDX_W-1:0]   sel_head;
  logic [CNT_W-1:0]   sel_count;
  logic [IDX_W-1:0]   rd_pos;
  logic [CNT_W-1:0]   eff_budget;
  logic               out_free;
  logic               out_load;

  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_sum;
  alu_flags_t         alu_flags;

  logic               dec_had;
  logic               dec_esc;
  logic [1:0]         dec_mode;
  logic [2:0]         dec_action;
  logic [PTS_W-1:0]   dec_src;

  // Ring position head + n, modulo the backlog depth
  function automatic logic [IDX_W-1:0] wrap_pos(input logic [IDX_W-1:0] h,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(h) + (CNT_W+1)'(n);
    if (t >= (CNT_W+1)'(BACKLOG_DEPTH)) begin
      t = t - (CNT_W+1)'(BACKLOG_DEPTH);
    end
    return IDX_W'(t);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                             input logic [IDX_W-1:0] p);
    return AW'(AW'(s) * AW'(BACKLOG_DEPTH)) + AW'(p);
  endfunction

  function automatic logic slot_visible(input logic [SLOT_W-1:0] s, input logic [7:0] m);
    return (32'(s) < 8) && m[3'(s)];
  endfunction

  msfas_alu u_alu (
    .req   (alu_req),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  // Slot whose backlog is looked at this cycle
  assign sel       = (state == ST_REF) ? '0 : cur;
  assign sel_head  = head[sel];
  assign sel_count = count[sel];
  assign rd_pos    = (state == ST_CH_RD && phase == PH_SCAN) ? wrap_pos(sel_head, k) : sel_head;
  assign mem_raddr = mem_addr(sel, rd_pos);
  assign mem_waddr = mem_addr(cur, wrap_pos(sel_head, sel_count));
  assign mem_we    = (state == ST_INGEST) && !req_flush && in_ok && (sel_count < eff_budget);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = ((state == ST_EMIT) || (state == ST_FINISH)) && pend_valid && out_free;
  assign s_tready  = (state == ST_IDLE);

  // Clamp the backlog budget to 1..depth
  always_comb begin
    if (backlog_budget == 5'd0) begin
      eff_budget = CNT_W'(1);
    end else if (32'(backlog_budget) > BACKLOG_DEPTH) begin
      eff_budget = CNT_W'(BACKLOG_DEPTH);
    end else begin
      eff_budget = CNT_W'(backlog_budget);
    end
  end

  // Operand select for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state)
      ST_PREP_A: begin
        alu_req.a = ALU_W'(window_ns);
        alu_req.b = ALU_W'(age_limit_ns);
      end
      ST_PREP_B: begin
        alu_req.sub = 1'b1;
        alu_req.b   = wq;
      end
      ST_PREP_C: begin
        alu_req.sub = 1'b1;
        alu_req.b   = ALU_W'(age_limit_ns);
      end
      ST_ES_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = sext_pts(mem_q);
        alu_req.b   = sext_pts(target);
      end
      ST_STALE_CHK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = sext_pts(target);
        alu_req.b   = ALU_W'(last_out_pts);
      end
      ST_FPTS: begin
        alu_req.a = ALU_W'(last_out_pts);
        alu_req.b = ALU_W'(frame_interval_ns);
        alu_req.c = ALU_W'(OPTS_MAX);
      end
      ST_CH_EV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = sext_pts(mem_q);
        alu_req.b   = sext_pts(target);
        if (phase == PH_TRIM) begin
          alu_req.c = neg_q;
        end else if (phase == PH_DROP) begin
          alu_req.c = neg_wq;
        end else begin
          alu_req.c = ALU_W'(window_ns);
        end
      end
      ST_DECIDE: begin
        alu_req.sub = 1'b1;
        alu_req.a   = sext_pts(target);
        alu_req.b   = sext_pts(hold_use[cur]);
        alu_req.c   = sext_pts(freeze_upgrade_ns);
      end
      default: alu_req = '0;
    endcase
  end

  // Compensation for a slot with no frame in its window
  always_comb begin
    dec_had  = has_hold[cur];
    dec_esc  = dec_had && !freeze_upgrade_ns[PTS_W-1] && alu_flags.gt;
    dec_mode = missing_mode;
    dec_src  = '0;
    if (dec_mode == MODE_SKIP && dec_had && cur == ref_slot) begin
      dec_mode = MODE_FREEZE;
    end
    if (dec_esc) begin
      dec_mode = MODE_PLACEHOLDER;
    end
    priority if (dec_mode == MODE_SKIP) begin
      dec_action = ACT_SKIP;
    end else if (dec_mode == MODE_BLACK) begin
      dec_action = ACT_BLACK;
    end else if (dec_mode == MODE_PLACEHOLDER || !dec_had) begin
      dec_action = ACT_PLACEHOLDER;
    end else begin
      dec_action = ACT_FREEZE;
      dec_src    = hold_pts[cur];
    end
  end

  // Backlog memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_pts;
    end
    mem_q <= mem[mem_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ns         <= WINDOW_RST;
      age_limit_ns      <= QUEUE_RST;
      freeze_upgrade_ns <= FREEZE_RST;
      missing_mode      <= MISSING_RST;
      reference_auto    <= REF_AUTO_RST;
      frame_interval_ns <= INTERVAL_RST;
      visible_mask      <= VISIBLE_RST;
      backlog_budget    <= BUDGET_RST;
      for (int i = 0; i < SLOTS; i++) begin
        head[i]     <= '0;
        count[i]    <= '0;
        hold_pts[i] <= '0;
        hold_use[i] <= '0;
      end
      has_hold       <= '0;
      ever_had       <= '0;
      ended          <= '0;
      last_out_pts   <= '0;
      last_out_valid <= 1'b0;
      state          <= ST_IDLE;
      phase          <= PH_TRIM;
      pend_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
      emitted        <= '0;
      found          <= 1'b0;
      stale_ctx      <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the result is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW:   window_ns         <= cfg_data[61:0];
          REG_QUEUE:    age_limit_ns      <= cfg_data[61:0];
          REG_FREEZE:   freeze_upgrade_ns <= cfg_data[62:0];
          REG_MISSING:  missing_mode      <= cfg_data[1:0];
          REG_REF_AUTO: reference_auto    <= cfg_data[0];
          REG_INTERVAL: frame_interval_ns <= cfg_data[29:0];
          REG_VISIBLE:  visible_mask      <= cfg_data[7:0];
          REG_BUDGET:   backlog_budget    <= cfg_data[4:0];
          default: ;
        endcase
      end

      unique case (state)
        // Take one transaction
        ST_IDLE: begin
          if (s_tvalid) begin
            req_flush <= s_tuser[0];
            in_ok     <= 32'(s_tdata[2:0]) < SLOTS;
            cur       <= SLOT_W'(s_tdata[2:0]);
            in_pts    <= s_tdata[65:3];
            emitted   <= '0;
            state     <= ST_PREP_A;
          end
        end
        // Derive the drop thresholds
        ST_PREP_A: begin
          wq    <= alu_sum;
          state <= ST_PREP_B;
        end
        ST_PREP_B: begin
          neg_wq <= alu_sum;
          state  <= ST_PREP_C;
        end
        ST_PREP_C: begin
          neg_q <= alu_sum;
          state <= ST_INGEST;
        end
        // Queue the arrival or mark all sources ended
        ST_INGEST: begin
          if (req_flush) begin
            ended <= '1;
          end else if (in_ok && sel_count < eff_budget) begin
            count[cur]    <= sel_count + CNT_W'(1);
            ever_had[cur] <= 1'b1;
          end
          state <= ST_REF;
        end
        // Pick the reference for the next frame
        ST_REF: begin
          priority if (emitted == FC_W'(FRAMES_PER_CALL)) begin
            state <= ST_FINISH;
          end else if (reference_auto) begin
            cur   <= '0;
            found <= 1'b0;
            state <= ST_ES_CHK;
          end else if (sel_count != '0) begin
            state <= ST_REF_MAIN;
          end else if (!ended[0] && ever_had[0]) begin
            state <= ST_FINISH;
          end else if (ended[0]) begin
            cur   <= '0;
            found <= 1'b0;
            state <= ST_ES_CHK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_REF_MAIN: begin
          target   <= mem_q;
          ref_slot <= '0;
          state    <= ST_STALE_CHK;
        end
        // Search the earliest visible backlog front
        ST_ES_CHK: begin
          if (slot_visible(cur, visible_mask) && sel_count != '0) begin
            state <= ST_ES_CMP;
          end else if (cur == LAST_SLOT) begin
            state <= ST_ES_END;
          end else begin
            cur <= cur + SLOT_W'(1);
          end
        end
        ST_ES_CMP: begin
          if (!found || alu_flags.lt) begin
            target   <= mem_q;
            ref_slot <= cur;
            found    <= 1'b1;
          end
          if (cur == LAST_SLOT) begin
            state <= ST_ES_END;
          end else begin
            cur   <= cur + SLOT_W'(1);
            state <= ST_ES_CHK;
          end
        end
        ST_ES_END: begin
          state <= found ? ST_STALE_CHK : ST_FINISH;
        end
        // A target not after the last output only advances the reference
        ST_STALE_CHK: begin
          if (last_out_valid && alu_flags.le) begin
            cur       <= ref_slot;
            phase     <= PH_DROP;
            stale_ctx <= 1'b1;
            found     <= 1'b0;
            k         <= '0;
            state     <= ST_CH_RD;
          end else begin
            state <= ST_FPTS;
          end
        end
        // Output timestamp, saturated
        ST_FPTS: begin
          if (last_out_valid) begin
            fpts <= alu_flags.gt ? OPTS_MAX : OPTS_W'(alu_sum);
          end else begin
            fpts <= '0;
          end
          key   <= !last_out_valid;
          cur   <= '0;
          state <= ST_SLOT_START;
        end
        ST_SLOT_START: begin
          if (!slot_visible(cur, visible_mask)) begin
            res_action <= ACT_HIDDEN;
            res_src    <= '0;
            state      <= ST_EMIT;
          end else begin
            phase     <= PH_TRIM;
            stale_ctx <= 1'b0;
            found     <= 1'b0;
            k         <= '0;
            state     <= ST_CH_RD;
          end
        end
        // Issue the backlog read for the current phase
        ST_CH_RD: begin
          unique case (phase)
            PH_TRIM: begin
              if (sel_count > CNT_W'(1)) begin
                state <= ST_CH_EV;
              end else begin
                phase <= PH_DROP;
              end
            end
            PH_DROP: state <= (sel_count != '0) ? ST_CH_EV : ST_CH_PICK;
            PH_SCAN: state <= (k < sel_count) ? ST_CH_EV : ST_CH_PICK;
            default: state <= ST_CH_PICK;
          endcase
        end
        // Judge one backlog entry
        ST_CH_EV: begin
          unique case (phase)
            PH_TRIM, PH_DROP: begin
              if (alu_flags.lt) begin
                head[cur]  <= wrap_pos(sel_head, CNT_W'(1));
                count[cur] <= sel_count - CNT_W'(1);
              end else if (phase == PH_TRIM) begin
                phase <= PH_DROP;
              end else begin
                phase <= PH_SCAN;
                k     <= '0;
              end
              state <= ST_CH_RD;
            end
            PH_SCAN: begin
              if (alu_flags.le) begin
                found  <= 1'b1;
                best   <= k;
                picked <= mem_q;
                k      <= k + CNT_W'(1);
                state  <= ST_CH_RD;
              end else begin
                state <= ST_CH_PICK;
              end
            end
            default: state <= ST_CH_PICK;
          endcase
        end
        // Consume the picked entry and the ones before it
        ST_CH_PICK: begin
          if (found) begin
            head[cur]     <= wrap_pos(sel_head, best + CNT_W'(1));
            count[cur]    <= sel_count - (best + CNT_W'(1));
            hold_pts[cur] <= picked;
            has_hold[cur] <= 1'b1;
            if (stale_ctx) begin
              state <= ST_REF;
            end else begin
              hold_use[cur] <= target;
              res_action    <= ACT_NEW;
              res_src       <= picked;
              state         <= ST_EMIT;
            end
          end else begin
            state <= stale_ctx ? ST_REF : ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_action <= dec_action;
          res_src    <= dec_src;
          state      <= ST_EMIT;
        end
        // Push the held decision out and hold the new one
        ST_EMIT: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_slot   <= pend_slot;
              out_action <= pend_action;
              out_src    <= pend_src;
              out_fpts   <= pend_fpts;
              out_key    <= pend_key;
              out_eof    <= pend_eof;
              out_last   <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_slot   <= 3'(cur);
            pend_action <= res_action;
            pend_src    <= res_src;
            pend_fpts   <= fpts;
            pend_key    <= key;
            pend_eof    <= (cur == LAST_SLOT);
            if (cur == LAST_SLOT) begin
              last_out_pts   <= fpts;
              last_out_valid <= 1'b1;
              emitted        <= emitted + FC_W'(1);
              state          <= ST_REF;
            end else begin
              cur   <= cur + SLOT_W'(1);
              state <= ST_SLOT_START;
            end
          end
        end
        // Release the final decision marked as last
        ST_FINISH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_slot   <= pend_slot;
            out_action <= pend_action;
            out_src    <= pend_src;
            out_fpts   <= pend_fpts;
            out_key    <= pend_key;
            out_eof    <= pend_eof;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'b0, out_fpts, out_src, out_action, out_slot};
  assign m_tlast = out_eof;
  assign m_tuser = {out_last, out_key};

endmodule

[design/msfas_checker.sv]
// Port-level checks for the frame alignment scheduler, bound to the top level.
module msfas_checker
  import msfas_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         m_tlast,
  input logic [1:0]   m_tuser
);

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An accepted input keeps the block busy for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Frame end marks exactly the highest slot
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'(SLOTS - 1))))
    else $error("end of frame on wrong slot");

  // The final result of an input closes a frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("last result inside a frame");

  // Only new and freeze decisions carry a source timestamp
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:3] != ACT_NEW && m_tdata[5:3] != ACT_FREEZE |-> m_tdata[68:6] == '0)
    else $error("source timestamp on a compensated slot");

endmodule

bind multi_source_frame_alignment_scheduler msfas_checker #(.SLOTS(SLOTS)) u_msfas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

[bench/tb_multi_source_frame_alignment_scheduler.sv]
// Self-checking testbench for the multi-source frame alignment scheduler.
module tb_multi_source_frame_alignment_scheduler;
  import msfas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;
  localparam int DEPTH = 16;
  localparam int FRAMES = 8;
  localparam longint unsigned MAX62 = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  sid;
    logic [2:0]  act;
    logic [62:0] src;
    logic [61:0] fpts;
    bit          key;
    bit          eof;
    bit          lst;
  } decision_t;

  typedef struct {
    bit         flush;
    logic [2:0] slot;
    longint     pts;
    bit         chk;
    logic [2:0] eact;
    longint     esrc;
  } stim_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // slot[2:0], pts[65:3], zero[71:66]
  logic [0:0]   s_tuser = '0;   // req_type[0]
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [135:0] m_tdata;        // slot_id, action, source_pts, frame_pts, zero
  logic         m_tlast;
  logic [1:0]   m_tuser;        // keyframe[0], last[1]

  multi_source_frame_alignment_scheduler u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Scheduler mirror: registers and per-slot state
  longint          win_ns, que_ns, frz_ns;
  longint unsigned ival_ns;
  logic [1:0]      miss_mode;
  bit              ref_auto;
  logic [7:0]      vis_mask;
  int              budget;
  longint          bl_pts[NSLOT][DEPTH];
  int              bl_head[NSLOT], bl_cnt[NSLOT];
  longint          hold_pts[NSLOT], hold_use[NSLOT];
  bit              has_hold[NSLOT], ever_had[NSLOT], ended[NSLOT];
  longint          last_fpts;
  bit              last_valid;

  decision_t decisions_due[$];
  int errors = 0;
  int n_items = 0, n_decisions = 0, n_flushes = 0;
  int idle_pct = 0, stall_pct = 0;
  int hold_reqs = 0, hold_done = 0, hold_left = 0;

  function automatic longint front_of(int s);
    return bl_pts[s][bl_head[s]];
  endfunction

  function automatic longint entry_of(int s, int i);
    return bl_pts[s][(bl_head[s] + i) % DEPTH];
  endfunction

  function automatic void drop_front(int s, int n);
    if (n > bl_cnt[s]) n = bl_cnt[s];
    bl_head[s] = (bl_head[s] + n) % DEPTH;
    bl_cnt[s] -= n;
  endfunction

  // Take the newest entry not later than target plus window, dropping late ones
  function automatic bit select_frame(int s, longint tgt, output longint picked);
    longint lim;
    int best;
    lim = -(win_ns + que_ns);
    picked = 0;
    while (bl_cnt[s] > 0 && front_of(s) - tgt < lim) drop_front(s, 1);
    if (bl_cnt[s] == 0) return 0;
    best = bl_cnt[s];
    for (int i = 0; i < bl_cnt[s]; i++) begin
      if (entry_of(s, i) - tgt <= win_ns) best = i;
      else break;
    end
    if (best == bl_cnt[s]) return 0;
    picked = entry_of(s, best);
    drop_front(s, best + 1);
    return 1;
  endfunction

  function automatic int earliest_shown(inout longint tgt);
    int r;
    r = -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (!vis_mask[s] || bl_cnt[s] == 0) continue;
      if (r < 0 || front_of(s) < tgt) begin
        tgt = front_of(s);
        r = s;
      end
    end
    return r;
  endfunction

  // Queue the arrival, then compose frames and append their slot decisions
  function automatic void compose_decisions(bit flush, int slot, longint pts);
    int bud, ref_s, emitted, n;
    longint tgt, pk;
    longint unsigned fp, sum;
    bit key, had, esc;
    logic [1:0] mode;
    decision_t d;
    emitted = 0;
    n = 0;
    if (flush) begin
      for (int s = 0; s < NSLOT; s++) ended[s] = 1;
    end else begin
      bud = budget < 1 ? 1 : (budget > DEPTH ? DEPTH : budget);
      if (bl_cnt[slot] < bud) begin
        bl_pts[slot][(bl_head[slot] + bl_cnt[slot]) % DEPTH] = pts;
        bl_cnt[slot]++;
        ever_had[slot] = 1;
      end
    end
    while (emitted < FRAMES) begin
      ref_s = -1;
      tgt = 0;
      if (ref_auto) ref_s = earliest_shown(tgt);
      else if (bl_cnt[0] > 0) begin
        tgt = front_of(0);
        ref_s = 0;
      end else if (!ended[0] && ever_had[0]) break;
      else if (ended[0]) ref_s = earliest_shown(tgt);
      if (ref_s < 0) break;
      // stale window: consume on the reference without producing a frame
      if (last_valid && tgt <= last_fpts) begin
        if (select_frame(ref_s, tgt, pk)) begin
          hold_pts[ref_s] = pk;
          has_hold[ref_s] = 1;
        end
        continue;
      end
      if (last_valid) begin
        sum = longint'(last_fpts) + ival_ns;
        fp = sum > MAX62 ? MAX62 : sum;
      end else fp = 0;
      key = !last_valid;
      for (int s = 0; s < NSLOT; s++) begin
        d.sid = s[2:0];
        d.src = '0;
        if (!vis_mask[s]) d.act = ACT_HIDDEN;
        else begin
          while (bl_cnt[s] > 1 && front_of(s) - tgt < -que_ns) drop_front(s, 1);
          if (select_frame(s, tgt, pk)) begin
            hold_pts[s] = pk;
            has_hold[s] = 1;
            hold_use[s] = tgt;
            d.act = ACT_NEW;
            d.src = pk[62:0];
          end else begin
            had = has_hold[s];
            esc = had && frz_ns >= 0 && tgt - hold_use[s] > frz_ns;
            mode = miss_mode;
            if (mode == MODE_SKIP && had && s == ref_s) mode = MODE_FREEZE;
            if (esc) mode = MODE_PLACEHOLDER;
            if (mode == MODE_SKIP) d.act = ACT_SKIP;
            else if (mode == MODE_BLACK) d.act = ACT_BLACK;
            else if (mode == MODE_PLACEHOLDER || !had) d.act = ACT_PLACEHOLDER;
            else begin
              d.act = ACT_FREEZE;
              d.src = hold_pts[s][62:0];
            end
          end
        end
        d.fpts = fp[61:0];
        d.key = key;
        d.eof = (s == NSLOT - 1);
        d.lst = 0;
        decisions_due.insert(decisions_due.size(), d);
        n++;
      end
      last_fpts = longint'(fp);
      last_valid = 1;
      emitted++;
    end
    if (n > 0) decisions_due[$].lst = 1;
  endfunction

  // Write one register and mirror it
  task automatic write_reg(logic [2:0] idx, logic [62:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_WINDOW:   win_ns = longint'(v[61:0]);
      REG_QUEUE:    que_ns = longint'(v[61:0]);
      REG_FREEZE:   frz_ns = longint'({v[62], v});
      REG_MISSING:  miss_mode = v[1:0];
      REG_REF_AUTO: ref_auto = v[0];
      REG_INTERVAL: ival_ns = v[29:0];
      REG_VISIBLE:  vis_mask = v[7:0];
      REG_BUDGET:   budget = v[4:0];
      default: ;
    endcase
  endtask

  // Offer one transaction, with an optional gap first; valid stays high across back-to-back items
  task automatic send_item(bit flush, logic [2:0] slot, longint pts, output int base);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, pts[62:0], slot};
    s_tuser <= flush;
    do @(posedge clk); while (!s_tready);
    base = decisions_due.size();
    compose_decisions(flush, slot, pts);
    n_items++;
    if (flush) n_flushes++;
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = 600;
        m_tready <= 0;
      end else m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted decision against the oldest pending one
  always @(posedge clk) begin
    decision_t g, e;
    if (!rst && m_tvalid && m_tready) begin
      g.sid = m_tdata[2:0];
      g.act = m_tdata[5:3];
      g.src = m_tdata[68:6];
      g.fpts = m_tdata[130:69];
      g.key = m_tuser[0];
      g.eof = m_tlast;
      g.lst = m_tuser[1];
      if (decisions_due.size() == 0) begin
        errors++;
        $display("%t unexpected decision: got %p", $time, g);
      end else begin
        e = decisions_due[0];
        decisions_due.delete(0);
        n_decisions++;
        if (g.sid !== e.sid || g.act !== e.act || g.src !== e.src || g.fpts !== e.fpts ||
            g.key !== e.key || g.eof !== e.eof || g.lst !== e.lst) begin
          errors++;
          $display("%t decision mismatch: expected %p got %p", $time, e, g);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("[multi_source_frame_alignment_scheduler] ERROR");
    $finish;
  end

  // Directed rows under reset settings (slot 0 main and only visible slot)
  stim_row_t dir_rows[10] = '{
    '{0, 3'd0, 0,                         1, ACT_NEW, 0},
    '{0, 3'd0, 33333333,                  1, ACT_NEW, 33333333},
    '{0, 3'd3, 5,                         0, ACT_NEW, 0},
    '{0, 3'd0, 1000000000,                1, ACT_NEW, 1000000000},
    '{0, 3'd0, -64'sd4611686018427387904, 0, ACT_NEW, 0},
    '{0, 3'd0, 64'sd4611686018427387903,  1, ACT_NEW, 64'sd4611686018427387903},
    '{0, 3'd7, 64'sd4611686018427387903,  0, ACT_NEW, 0},
    '{0, 3'd1, -1,                        0, ACT_NEW, 0},
    '{0, 3'd5, 0,                         0, ACT_NEW, 0},
    '{0, 3'd0, 64'sd4611686018427387903,  0, ACT_NEW, 0}
  };

  initial begin
    int base, r;
    logic [2:0] sl;
    longint tl, p, step;
    logic [63:0] rnd;
    // reset state of the mirror
    win_ns = 40000000; que_ns = 500000000; frz_ns = 64'sd10000000000;
    miss_mode = MODE_FREEZE; ref_auto = 0; ival_ns = 33333333; vis_mask = 8'd1; budget = 15;
    for (int s = 0; s < NSLOT; s++) begin
      bl_head[s] = 0; bl_cnt[s] = 0; hold_pts[s] = 0; hold_use[s] = 0;
      has_hold[s] = 0; ever_had[s] = 0; ended[s] = 0;
    end
    last_fpts = 0;
    last_valid = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].flush, dir_rows[i].slot, dir_rows[i].pts, base);
      if (dir_rows[i].chk && (decisions_due.size() <= base ||
          decisions_due[base].act !== dir_rows[i].eact ||
          decisions_due[base].src !== dir_rows[i].esrc[62:0])) begin
        errors++;
        $display("%t directed row %0d: expected action %0d src %0d", $time, i,
                 dir_rows[i].eact, dir_rows[i].esrc);
      end
    end

    // random phases, each with its own register setting and an idling mode
    tl = 64'sd4611686018427387903 - 64'sd100000000000;
    for (int ph = 0; ph < 5; ph++) begin
      s_tvalid <= 0;
      wait (decisions_due.size() == 0);
      repeat (3000) @(posedge clk);
      case (ph)
        0: begin
          write_reg(REG_VISIBLE, 63'hFF); write_reg(REG_BUDGET, 63'd4);
          write_reg(REG_WINDOW, 63'd10000000); write_reg(REG_QUEUE, 63'd100000000);
          write_reg(REG_FREEZE, 63'd50000000); write_reg(REG_MISSING, MODE_FREEZE);
          write_reg(REG_REF_AUTO, 63'd0); write_reg(REG_INTERVAL, 63'd33333333);
        end
        1: begin
          write_reg(REG_MISSING, MODE_BLACK); write_reg(REG_REF_AUTO, 63'd1);
          write_reg(REG_VISIBLE, 63'h5B); write_reg(REG_BUDGET, 63'd0);
          write_reg(REG_WINDOW, 63'd0); write_reg(REG_QUEUE, 63'd0);
        end
        2: begin
          write_reg(REG_MISSING, MODE_PLACEHOLDER); write_reg(REG_BUDGET, 63'd31);
          write_reg(REG_FREEZE, {63{1'b1}}); write_reg(REG_INTERVAL, 63'd1);
          write_reg(REG_WINDOW, 63'h3FFF_FFFF_FFFF_FFFF);
          write_reg(REG_QUEUE, 63'h3FFF_FFFF_FFFF_FFFF); write_reg(REG_REF_AUTO, 63'd0);
          write_reg(REG_VISIBLE, 63'hFE);
        end
        3: begin
          write_reg(REG_MISSING, MODE_SKIP); write_reg(REG_FREEZE, 63'd0);
          write_reg(REG_INTERVAL, 63'd1000000000); write_reg(REG_VISIBLE, 63'hA5);
          write_reg(REG_WINDOW, 63'd40000000); write_reg(REG_QUEUE, 63'd500000000);
          write_reg(REG_BUDGET, 63'd16);
        end
        default: begin
          write_reg(REG_MISSING, MODE_FREEZE); write_reg(REG_REF_AUTO, 63'd0);
          write_reg(REG_FREEZE, 63'd100000000); write_reg(REG_INTERVAL, 63'd40000000);
          write_reg(REG_VISIBLE, 63'h00); write_reg(REG_BUDGET, 63'd8);
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (ph == 0) hold_reqs++;
      for (int k = 0; k < 50; k++) begin
        // last phase: show all slots partway, and end the sources once
        if (ph == 4 && k == 20) begin
          s_tvalid <= 0;
          wait (decisions_due.size() == 0);
          repeat (3000) @(posedge clk);
          write_reg(REG_VISIBLE, 63'hFF);
        end
        r = $urandom_range(99);
        sl = ($urandom_range(99) < 40) ? 3'd0 : 3'($urandom_range(7));
        step = $urandom_range(0, 60000000);
        tl += step;
        if (ph == 4 && k == 35) begin
          send_item(1, 3'($urandom_range(7)), tl, base);
          continue;
        end
        if (r < 80) p = tl + $signed($urandom_range(0, 20000000)) - 10000000;
        else if (r < 90) begin
          rnd = {$urandom, $urandom};
          p = longint'({rnd[62], rnd[62:0]});
        end else p = tl - $urandom_range(0, 900000000);
        send_item(0, sl, p, base);
      end
    end

    s_tvalid <= 0;
    wait (decisions_due.size() == 0);
    repeat (3000) @(posedge clk);
    if (decisions_due.size() != 0) begin
      errors++;
      $display("%t %0d decisions never arrived", $time, decisions_due.size());
    end
    $display("Covered %0d inputs (%0d flushes), %0d slot decisions over 6 register settings,",
             n_items, n_flushes, n_decisions);
    $display("with sender gaps, receiver stalls and a long receiver hold-off; %0d errors.",
             errors);
    if (errors == 0) $display("[multi_source_frame_alignment_scheduler] OK");
    else $display("[multi_source_frame_alignment_scheduler] ERROR");
    $finish;
  end

endmodule
